### design/stifr_pkg.sv
// shared types and constants for the sorted table
package stifr_pkg;

  localparam int unsigned DepthDefault     = 64;
  localparam int unsigned ValueBitsDefault = 32;

  localparam int unsigned KindW   = 2;
  localparam int unsigned ItemW   = 32;
  localparam int unsigned PosInW  = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosOutW = 7;

  typedef enum logic [KindW-1:0] {
    KIND_FIND   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ItemW-1:0]  item_value;
    logic [PosInW-1:0] position_in;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PosOutW-1:0] position_out;
    logic [ItemW-1:0]   value_out;
    logic [PosOutW-1:0] entry_count;
  } rsp_t;

endpackage

### design/stifr_if.sv
// valid/ready channel carrying one payload
interface stifr_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/sorted_table_insert_find_remove.sv
// sorted table: binary search, insert with shift up, remove with shift down
//
// Requests enter on req_i (kind, item_value, position_in); one response per
// request leaves on rsp_o (status, position_out, value_out, entry_count).
// Entries live in a single-write, single-read memory with a registered read
// port. A find or insert does a binary search over the n stored entries in
// at most ceil(log2(n+1)) probes, each an address step and then a compare;
// then the final slot is read, the result is decided and the response is
// loaded. An insert that adds a value then moves each entry from the slot
// upward up by one, each with a read and then a write, and then writes the
// new value into the slot. A remove moves each entry above the position
// down by one, each with a read and then a write.
// One request is in work at a time; req_i.ready is high while idle and no
// response is waiting, so the next request is taken at the earliest in the
// cycle after the response transfer.
// Reset clears the count to zero and empties the response register; entry
// contents are not cleared, and only entries below the count at request
// time are ever used. A stalled receiver holds the response in its register
// and further requests wait until it is taken.
module sorted_table_insert_find_remove #(
  parameter int unsigned DEPTH      = stifr_pkg::DepthDefault,
  parameter int unsigned VALUE_BITS = stifr_pkg::ValueBitsDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  stifr_if.sink   req_i,
  stifr_if.source rsp_o
);
  import stifr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = VALUE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_CMP, S_LOAD, S_CHECK, S_SRD, S_SWR, S_PUT, S_OUT
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q, lo_q, hi_q, idx_q;
  logic [VW-1:0]   val_q;
  logic [1:0]      kind_q;
  logic            rsp_valid_q;
  rsp_t            rsp_q;
  logic [VW-1:0]   rdata_q;
  logic [VW-1:0]   mem_q [DEPTH];
  logic [AW-1:0]   raddr;
  logic            re;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [VW-1:0]   wdata;
  logic [CW-1:0]   mid;
  logic [VW-1:0]   req_val;

  assign req_val     = VW >= ItemW ? VW'(req_i.payload.item_value)
                                   : req_i.payload.item_value[VW-1:0];
  assign mid         = lo_q + ((hi_q - lo_q) >> 1);
  assign req_i.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // memory access steering
  always_comb begin
    re    = 1'b0;
    raddr = mid[AW-1:0];
    we    = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = rdata_q;
    case (state_q)
      S_PROBE: begin
        re = 1'b1;
        raddr = mid[AW-1:0];
      end
      S_LOAD: begin
        re = 1'b1;
        raddr = lo_q[AW-1:0];
      end
      S_SRD: begin
        re = 1'b1;
        raddr = kind_q == KIND_REMOVE ? AW'(idx_q + 1'b1) : AW'(idx_q - 1'b1);
      end
      S_SWR: begin
        we = 1'b1;
        waddr = idx_q[AW-1:0];
        wdata = rdata_q;
      end
      S_PUT: begin
        we = 1'b1;
        waddr = lo_q[AW-1:0];
        wdata = val_q;
      end
      default: ;
    endcase
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      lo_q <= '0; hi_q <= '0; idx_q <= '0; kind_q <= '0; val_q <= '0;
      rsp_q <= '0;
    end else begin
      // response handshake
      if (state_q == S_OUT) rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.valid && req_i.ready) begin
            kind_q <= req_i.payload.kind;
            val_q  <= req_val;
            lo_q   <= '0;
            hi_q   <= count_q;
            idx_q  <= CW'(req_i.payload.position_in);
            rsp_q.position_out <= '0;
            rsp_q.value_out    <= '0;
            rsp_q.entry_count  <= PosOutW'(count_q);
            case (req_i.payload.kind)
              KIND_FIND, KIND_INSERT: state_q <= count_q == '0 ? S_CHECK : S_PROBE;
              KIND_REMOVE: begin
                rsp_q.position_out <= PosOutW'(req_i.payload.position_in);
                if (CW'(req_i.payload.position_in) >= count_q) begin
                  rsp_q.status <= ST_BAD_POS;
                  state_q <= S_OUT;
                end else begin
                  rsp_q.status <= ST_DONE;
                  state_q <= (CW'(req_i.payload.position_in) + 1'b1 < count_q)
                             ? S_SRD : S_OUT;
                  count_q <= count_q - 1'b1;
                  rsp_q.entry_count <= PosOutW'(count_q - 1'b1);
                end
              end
              default: begin
                rsp_q.status <= ST_BAD_POS;
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_PROBE: state_q <= S_CMP;
        S_CMP: begin
          if (rdata_q < val_q) lo_q <= mid + 1'b1;
          else hi_q <= mid;
          if (rdata_q < val_q ? (mid + 1'b1 >= hi_q) : (mid <= lo_q)) begin
            state_q <= S_LOAD;
          end else begin
            state_q <= S_PROBE;
          end
        end
        S_LOAD: state_q <= S_CHECK;
        S_CHECK: begin
          // rdata_q holds the entry at lo when lo < count
          if (lo_q < count_q && rdata_q == val_q) begin
            rsp_q.status <= ST_DONE;
            rsp_q.position_out <= PosOutW'(lo_q);
            rsp_q.value_out <= ItemW'(val_q);
            state_q <= S_OUT;
          end else if (kind_q == KIND_FIND) begin
            rsp_q.status <= ST_NOT_FOUND;
            rsp_q.position_out <= PosOutW'(count_q);
            state_q <= S_OUT;
          end else if (count_q >= CW'(DEPTH)) begin
            rsp_q.status <= ST_FULL;
            rsp_q.position_out <= PosOutW'(count_q);
            state_q <= S_OUT;
          end else begin
            rsp_q.status <= ST_DONE;
            rsp_q.position_out <= PosOutW'(lo_q);
            rsp_q.value_out <= ItemW'(val_q);
            count_q <= count_q + 1'b1;
            rsp_q.entry_count <= PosOutW'(count_q + 1'b1);
            idx_q <= count_q;
            state_q <= (lo_q == count_q) ? S_PUT : S_SRD;
          end
        end
        S_SRD: state_q <= S_SWR;
        S_SWR: begin
          if (kind_q == KIND_REMOVE) begin
            idx_q <= idx_q + 1'b1;
            state_q <= (CW'(idx_q + 1'b1) < count_q) ? S_SRD : S_OUT;
          end else begin
            idx_q <= idx_q - 1'b1;
            state_q <= (CW'(idx_q - 1'b1) == lo_q) ? S_PUT : S_SRD;
          end
        end
        // new value into the opened slot
        S_PUT: state_q <= S_OUT;
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
